/* src/mroo_pkg.sv */
package mroo_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int HGT_W    = $clog2(MAX_ROWS + 1);
   localparam int CNT_W    = $clog2(MAX_COLS + 1);
   localparam int AREA_W   = 13;
   localparam int CSR_W    = 7;
   localparam logic [AREA_W-1:0] AREA_CAP = {AREA_W{1'b1}};
   localparam logic [CSR_W-1:0]  COL_RESET = CSR_W'(MAX_COLS);

   typedef struct packed {
      logic filled;
      logic last;
   } item_type;

   typedef struct packed {
      logic [COL_W-1:0] left;
      logic [HGT_W-1:0] height;
   } stk_entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HREAD,
      S_SCAN,
      S_SWAIT,
      S_FWAIT,
      S_FLUSH
   } state_type;

endpackage

/* src/mroo_ram.sv */
module mroo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mroo_front.sv */
module mroo_front import mroo_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  item_type req_item,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type   buf_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = buf_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= req_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

/* src/mroo_back.sv */
module mroo_back import mroo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              q_pop,
   input  logic [CSR_W-1:0]  col_count,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [AREA_W-1:0] rsp_max_area
);

   state_type           state_ff, state_in;
   logic [COL_W-1:0]    pos_ff, pos_in;
   logic [HGT_W-1:0]    h_ff, h_in;
   logic [COL_W-1:0]    left_ff, left_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [AREA_W-1:0]   best_ff, best_in;
   item_type            cur_ff, cur_in;
   logic [MAX_COLS-1:0] hvalid_ff, hvalid_in;
   logic                out_valid_ff, out_valid_in;
   logic [AREA_W-1:0]   out_area_ff, out_area_in;

   logic                h_wr;
   logic [HGT_W-1:0]    h_rd, h_old, h_new;
   logic                s_wr;
   stk_entry_type       s_wdata, s_top;
   logic [CNT_W-1:0]    wid, right;
   logic [CNT_W-1:0]    span;
   logic [2*CNT_W-1:0]  prod;
   logic [AREA_W-1:0]   area;
   logic                end_row;

   mroo_ram #(.WIDTH(HGT_W), .DEPTH(MAX_COLS)) u_heights (
      .clock   (clock),
      .wr_en   (h_wr),
      .wr_addr (pos_ff),
      .wr_data (h_new),
      .rd_addr (pos_ff),
      .rd_data (h_rd)
   );

   mroo_ram #(.WIDTH($bits(stk_entry_type)), .DEPTH(MAX_COLS)) u_stack (
      .clock   (clock),
      .wr_en   (s_wr),
      .wr_addr (fill_ff[COL_W-1:0]),
      .wr_data (s_wdata),
      .rd_addr (COL_W'(fill_ff - CNT_W'(1))),
      .rd_data (s_top)
   );

   always_comb begin
      if (col_count == '0) begin
         wid = CNT_W'(1);
      end else if (col_count > CSR_W'(MAX_COLS)) begin
         wid = CNT_W'(MAX_COLS);
      end else begin
         wid = CNT_W'(col_count);
      end
      end_row = cur_ff.last || (CNT_W'(pos_ff) + CNT_W'(1) >= wid);
      h_old   = hvalid_ff[pos_ff] ? h_rd : '0;
      if (!cur_ff.filled) begin
         h_new = '0;
      end else if (h_old < HGT_W'(MAX_ROWS)) begin
         h_new = h_old + HGT_W'(1);
      end else begin
         h_new = HGT_W'(MAX_ROWS);
      end
      right = (state_ff == S_FLUSH) ? CNT_W'(pos_ff) + CNT_W'(1) : CNT_W'(pos_ff);
      span  = right - CNT_W'(s_top.left);
      prod  = (2*CNT_W)'(s_top.height) * (2*CNT_W)'(span);
      area  = (prod > (2*CNT_W)'(AREA_CAP)) ? AREA_CAP : AREA_W'(prod);
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      h_in         = h_ff;
      left_in      = left_ff;
      fill_in      = fill_ff;
      best_in      = best_ff;
      cur_in       = cur_ff;
      hvalid_in    = hvalid_ff;
      out_area_in  = out_area_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      h_wr         = 1'b0;
      s_wr         = 1'b0;
      s_wdata      = '{left: left_ff, height: h_ff};
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               state_in = S_HREAD;
            end
         end
         S_HREAD: begin
            h_wr              = 1'b1;
            hvalid_in[pos_ff] = 1'b1;
            h_in              = h_new;
            left_in           = pos_ff;
            state_in          = S_SCAN;
         end
         S_SCAN: begin
            if (fill_ff != '0 && s_top.height >= h_ff) begin
               if (area > best_ff) begin
                  best_in = area;
               end
               fill_in  = fill_ff - CNT_W'(1);
               left_in  = s_top.left;
               state_in = S_SWAIT;
            end else begin
               s_wr    = 1'b1;
               fill_in = fill_ff + CNT_W'(1);
               if (end_row) begin
                  state_in = S_FWAIT;
               end else begin
                  pos_in   = pos_ff + COL_W'(1);
                  state_in = S_IDLE;
               end
            end
         end
         S_SWAIT: begin
            state_in = S_SCAN;
         end
         S_FWAIT: begin
            state_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (fill_ff != '0) begin
               if (area > best_ff) begin
                  best_in = area;
               end
               fill_in  = fill_ff - CNT_W'(1);
               state_in = S_FWAIT;
            end else if (!cur_ff.last) begin
               pos_in   = '0;
               state_in = S_IDLE;
            end else if (!(out_valid_ff && rsp_stall)) begin
               out_valid_in = 1'b1;
               out_area_in  = best_ff;
               best_in      = '0;
               hvalid_in    = '0;
               pos_in       = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      h_ff        <= h_in;
      left_ff     <= left_in;
      cur_ff      <= cur_in;
      out_area_ff <= out_area_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         fill_ff      <= '0;
         best_ff      <= '0;
         hvalid_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         best_ff      <= best_in;
         hvalid_ff    <= hvalid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_max_area = out_area_ff;

endmodule

/* src/maximal_rectangle_of_ones_top.sv */
// Finds the largest all-ones rectangle in a binary matrix fed one cell per item,
// in row-major order. The user must write the row width through csr_wr_en and
// csr_wr_data only while the block is idle; the block does not enforce it. A width
// of zero acts as one and widths above 64 act as 64. Each input item carries
// req_cell_req and req_last_cell and is accepted when req_valid is high and req_stall
// is low. A two-entry queue sits in front of the histogram engine, so items are taken
// while the engine works. Only the item marked last produces a result, rsp_max_area,
// held on the rsp_ channel until rsp_stall is low; all matrix state is cleared as
// the result is produced. Each cell passes through the height read and the stack
// scan, and every stack pop waits on the registered read of the stack memory; at row
// end the remaining stack entries are flushed the same way. The result is registered
// once the last cell's flush ends and any earlier result has been taken.
// If the receiver stalls, the engine holds at the end of the next matrix until the
// previous result has been taken.
// Reset is synchronous and active high; it empties the queue, clears the column
// heights and the best area, and sets the row width to 64.
module maximal_rectangle_of_ones_top import mroo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cell_req,
   input  logic              req_last_cell,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [AREA_W-1:0] rsp_max_area,
   input  logic              csr_wr_en,
   input  logic [CSR_W-1:0]  csr_wr_data
);

   logic [CSR_W-1:0] col_count_ff;
   item_type         req_item, q_item;
   logic             q_valid, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= COL_RESET;
      end else if (csr_wr_en) begin
         col_count_ff <= csr_wr_data;
      end
   end

   assign req_item = '{filled: req_cell_req, last: req_last_cell};

   mroo_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   mroo_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .col_count    (col_count_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_max_area (rsp_max_area)
   );

endmodule
